>>> rtl/rk4s_pkg.sv
// shared types, widths and constants for the rk4 linear ode stepper
// used by rk4s_mul and rk4_linear_ode_stepper_core; no dependencies
package rk4s_pkg;

   // fixed point format of the datapath
   localparam int DATA_WIDTH = 48;
   localparam int FRAC_BITS  = 24;

   // widths of the external fields
   localparam int FIELD_W   = 48;
   localparam int STEP_W    = 47;
   localparam int LIMIT_W   = 16;
   localparam int CSR_IDX_W = 3;

   // multiplier split into half-width partial products
   localparam int HALF_W = (DATA_WIDTH + 1) / 2;
   localparam int MAG_W  = 2 * HALF_W;
   localparam int PROD_W = DATA_WIDTH + FRAC_BITS;

   // divide by six: halve, then divide by three a digit of bits a cycle
   localparam int DIV_DIGIT = 8;
   localparam int DIV_STEPS = (DATA_WIDTH - 1 + DIV_DIGIT - 1) / DIV_DIGIT;
   localparam int DIV_W     = DIV_STEPS * DIV_DIGIT;
   localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [FIELD_W-1:0]    field_type;
   typedef logic [LIMIT_W-1:0]    limit_type;

   // status of the shared multiplier seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_START_TIME  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_VALUE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_SIZE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_CONST  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_TIME   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_VALUE  = 3'd6;

   // reset values of the configuration registers
   localparam data_type  STEP_SIZE_RESET  = data_type'(1677722);
   localparam limit_type STEP_LIMIT_RESET = limit_type'(100);

   // magnitude of a two's complement value, most negative maps to 2^(w-1)
   function automatic data_type mag_of(input data_type v);
      return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

>>> rtl/rk4s_mul.sv
// shared signed fixed point multiplier, four half-width partial products
// depends on rk4s_pkg
module rk4s_mul
   import rk4s_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  data_type     op_a,
   input  data_type     op_b,
   output mul_stat_type stat,
   output data_type     result
);

   localparam logic [2:0] CNT_ACC_FIRST = 3'd1;
   localparam logic [2:0] CNT_ACC_LAST  = 3'd4;
   localparam logic [2:0] CNT_LAST      = 3'd5;

   logic              active_ff, active_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [MAG_W-1:0]  mag_a_ff, mag_a_in;
   logic [MAG_W-1:0]  mag_b_ff, mag_b_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  pp_ff, pp_in;
   logic [1:0]        sh_ff, sh_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   data_type          res_ff, res_in;
   logic              done_ff, done_in;

   logic [HALF_W-1:0] a_half, b_half;
   logic [PROD_W-1:0] pp_ext, pp_shifted, acc_signed;

   // partial product select: low or high half of each magnitude
   assign a_half = cnt_ff[0] ? mag_a_ff[MAG_W-1:HALF_W] : mag_a_ff[HALF_W-1:0];
   assign b_half = cnt_ff[1] ? mag_b_ff[MAG_W-1:HALF_W] : mag_b_ff[HALF_W-1:0];
   assign pp_in  = a_half * b_half;
   assign sh_in  = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};

   // align the registered partial product
   assign pp_ext = PROD_W'(pp_ff);
   always_comb begin
      unique case (sh_ff)
         2'd0:    pp_shifted = pp_ext;
         2'd1:    pp_shifted = pp_ext << HALF_W;
         2'd2:    pp_shifted = pp_ext << (2 * HALF_W);
         default: pp_shifted = '0;
      endcase
   end

   // sign restore, then drop the fraction bits
   assign acc_signed = neg_ff ? (~acc_ff + 1'b1) : acc_ff;

   // sequencing of one multiplication
   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      mag_a_in  = mag_a_ff;
      mag_b_in  = mag_b_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      res_in    = res_ff;
      done_in   = 1'b0;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         mag_a_in  = MAG_W'(mag_of(op_a));
         mag_b_in  = MAG_W'(mag_of(op_b));
         neg_in    = op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
         acc_in    = '0;
      end else if (active_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff >= CNT_ACC_FIRST && cnt_ff <= CNT_ACC_LAST) begin
            acc_in = acc_ff + pp_shifted;
         end
         if (cnt_ff == CNT_LAST) begin
            active_in = 1'b0;
            done_in   = 1'b1;
            res_in    = acc_signed[PROD_W-1:FRAC_BITS];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         done_ff   <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
      pp_ff    <= pp_in;
      sh_ff    <= sh_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
   end

   assign stat.busy = active_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule

>>> rtl/rk4_linear_ode_stepper_core.sv
// rk4 stepper for dx/dt = c0 + c1*t + c2*x, signed q23.24 fixed point
// depends on rk4s_pkg and rk4s_mul
//
// usage
//  configuration: write registers through csr_wr_en/csr_index/csr_wdata
//  while the block is idle; indexes follow start time, start value, step
//  size, step limit, c0, c1, c2.
//  request channel: one word carries req_restart. restart reloads the start
//  point and returns it; otherwise one rk4 step of size h is taken and the
//  new (t, x) returned. once step_limit steps are taken an advance returns
//  the held point with rsp_done_res set.
//  sequencing: a restart or refused advance goes from acceptance straight to
//  the emit state; an advance runs eleven multiplier passes, the divide by
//  six, an update and an emit. req_stall is high while a word is in work,
//  so a new word is taken only once the last has been emitted.
//  response channel: a one-entry output register; a new request may be
//  taken while a finished response still waits, and a stalled response
//  holds its payload until taken.
//  reset: synchronous, active high; registers take their reset values and
//  the point (t, x, step count) is cleared to zero.
module rk4_linear_ode_stepper_core
   import rk4s_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output field_type            rsp_time_out,
   output field_type            rsp_value_out,
   output logic                 rsp_done_res,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  field_type            csr_wdata
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_UPD   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   // multiplier passes of one step, in order
   localparam logic [3:0] OP_K1_T  = 4'd0;   // c1 * t
   localparam logic [3:0] OP_K1_X  = 4'd1;   // c2 * x
   localparam logic [3:0] OP_H_K1  = 4'd2;   // h * k1
   localparam logic [3:0] OP_MID_T = 4'd3;   // c1 * (t + h/2)
   localparam logic [3:0] OP_K2_X  = 4'd4;   // c2 * x2
   localparam logic [3:0] OP_H_K2  = 4'd5;   // h * k2
   localparam logic [3:0] OP_K3_X  = 4'd6;   // c2 * x3
   localparam logic [3:0] OP_H_K3  = 4'd7;   // h * k3
   localparam logic [3:0] OP_END_T = 4'd8;   // c1 * (t + h)
   localparam logic [3:0] OP_K4_X  = 4'd9;   // c2 * x4
   localparam logic [3:0] OP_H_SUM = 4'd10;  // h * weighted sum

   localparam logic [2:0] DIVISOR = 3'd3;

   logic [2:0]           state_ff, state_in;
   logic [3:0]           op_ff, op_in;

   // configuration registers
   data_type             start_time_ff, start_time_in;
   data_type             start_value_ff, start_value_in;
   data_type             step_size_ff, step_size_in;
   limit_type            step_limit_ff, step_limit_in;
   data_type             coef_const_ff, coef_const_in;
   data_type             coef_time_ff, coef_time_in;
   data_type             coef_value_ff, coef_value_in;

   // integration state
   data_type             cur_time_ff, cur_time_in;
   data_type             cur_value_ff, cur_value_in;
   limit_type            steps_ff, steps_in;

   // working registers of one step
   data_type             mid_time_ff, mid_time_in;
   data_type             end_time_ff, end_time_in;
   data_type             base_ff, base_in;
   data_type             k_ff, k_in;
   data_type             ksum_ff, ksum_in;
   data_type             xa_ff, xa_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [1:0]           rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 div_neg_ff, div_neg_in;
   logic                 done_ff, done_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   field_type            rsp_time_ff, rsp_time_in;
   field_type            rsp_value_ff, rsp_value_in;
   logic                 rsp_done_ff, rsp_done_in;

   // shared multiplier
   logic                 mul_start;
   data_type             mul_a, mul_b, mul_res;
   mul_stat_type         mul_stat;

   // divider digit
   logic [1:0]           rem_v;
   logic [2:0]           trial;
   logic [DIV_DIGIT-1:0] qbits;
   logic [DIV_W-1:0]     div_shift;
   data_type             quo;
   data_type             prod_mag;

   logic                 req_take;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign mul_start = (state_ff == S_ISSUE);

   // operand select for the shared multiplier
   always_comb begin
      unique case (op_ff)
         OP_K1_T:  begin mul_a = coef_time_ff;  mul_b = cur_time_ff;  end
         OP_K1_X:  begin mul_a = coef_value_ff; mul_b = cur_value_ff; end
         OP_H_K1:  begin mul_a = step_size_ff;  mul_b = k_ff;         end
         OP_MID_T: begin mul_a = coef_time_ff;  mul_b = mid_time_ff;  end
         OP_K2_X:  begin mul_a = coef_value_ff; mul_b = xa_ff;        end
         OP_H_K2:  begin mul_a = step_size_ff;  mul_b = k_ff;         end
         OP_K3_X:  begin mul_a = coef_value_ff; mul_b = xa_ff;        end
         OP_H_K3:  begin mul_a = step_size_ff;  mul_b = k_ff;         end
         OP_END_T: begin mul_a = coef_time_ff;  mul_b = end_time_ff;  end
         OP_K4_X:  begin mul_a = coef_value_ff; mul_b = xa_ff;        end
         OP_H_SUM: begin mul_a = step_size_ff;  mul_b = ksum_ff;      end
         default:  begin mul_a = '0;            mul_b = '0;           end
      endcase
   end

   rk4s_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .stat   (mul_stat),
      .result (mul_res)
   );

   // one digit of the divide by three, remainder carried between cycles
   always_comb begin
      rem_v = rem_ff;
      trial = '0;
      qbits = '0;
      for (int i = 0; i < DIV_DIGIT; i++) begin
         trial = {rem_v, div_ff[DIV_W-1-i]};
         if (trial >= DIVISOR) begin
            qbits[DIV_DIGIT-1-i] = 1'b1;
            rem_v                = 2'(trial - DIVISOR);
         end else begin
            qbits[DIV_DIGIT-1-i] = 1'b0;
            rem_v                = trial[1:0];
         end
      end
      div_shift = {div_ff[DIV_W-DIV_DIGIT-1:0], qbits};
   end

   assign quo      = data_type'(div_ff);
   assign prod_mag = mag_of(mul_res);

   // sequencer and datapath next state
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      start_time_in  = start_time_ff;
      start_value_in = start_value_ff;
      step_size_in   = step_size_ff;
      step_limit_in  = step_limit_ff;
      coef_const_in  = coef_const_ff;
      coef_time_in   = coef_time_ff;
      coef_value_in  = coef_value_ff;
      cur_time_in    = cur_time_ff;
      cur_value_in   = cur_value_ff;
      steps_in       = steps_ff;
      mid_time_in    = mid_time_ff;
      end_time_in    = end_time_ff;
      base_in        = base_ff;
      k_in           = k_ff;
      ksum_in        = ksum_ff;
      xa_in          = xa_ff;
      div_in         = div_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      div_neg_in     = div_neg_ff;
      done_in        = done_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_time_in    = rsp_time_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_done_in    = rsp_done_ff;

      // configuration writes
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_START_TIME:  start_time_in  = data_type'($signed(csr_wdata));
            REG_START_VALUE: start_value_in = data_type'($signed(csr_wdata));
            REG_STEP_SIZE:   step_size_in   = data_type'(csr_wdata[STEP_W-1:0]);
            REG_STEP_LIMIT:  step_limit_in  = csr_wdata[LIMIT_W-1:0];
            REG_COEF_CONST:  coef_const_in  = data_type'($signed(csr_wdata));
            REG_COEF_TIME:   coef_time_in   = data_type'($signed(csr_wdata));
            REG_COEF_VALUE:  coef_value_in  = data_type'($signed(csr_wdata));
            default: ;
         endcase
      end

      unique case (state_ff)
         // take a word: restart and refused steps go straight to emit
         S_IDLE: begin
            if (req_take) begin
               if (req_restart) begin
                  cur_time_in  = start_time_ff;
                  cur_value_in = start_value_ff;
                  steps_in     = '0;
                  done_in      = 1'b0;
                  state_in     = S_EMIT;
               end else if (steps_ff >= step_limit_ff) begin
                  done_in  = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  done_in     = 1'b0;
                  mid_time_in = cur_time_ff + {1'b0, step_size_ff[DATA_WIDTH-1:1]};
                  end_time_in = cur_time_ff + step_size_ff;
                  op_in       = OP_K1_T;
                  state_in    = S_ISSUE;
               end
            end
         end

         // launch a multiply; fold the constant part of k into the sum
         S_ISSUE: begin
            unique case (op_ff)
               OP_K1_X:          ksum_in = base_ff;
               OP_K2_X, OP_K3_X: ksum_in = ksum_ff + {base_ff[DATA_WIDTH-2:0], 1'b0};
               OP_K4_X:          ksum_in = ksum_ff + base_ff;
               default: ;
            endcase
            state_in = S_MUL;
         end

         // consume the product
         S_MUL: begin
            if (mul_stat.done) begin
               unique case (op_ff)
                  OP_K1_T, OP_MID_T, OP_END_T: begin
                     base_in = coef_const_ff + mul_res;
                  end
                  OP_K1_X, OP_K4_X: begin
                     k_in    = base_ff + mul_res;
                     ksum_in = ksum_ff + mul_res;
                  end
                  OP_K2_X, OP_K3_X: begin
                     k_in    = base_ff + mul_res;
                     ksum_in = ksum_ff + {mul_res[DATA_WIDTH-2:0], 1'b0};
                  end
                  OP_H_K1, OP_H_K2: begin
                     xa_in = cur_value_ff
                           + {mul_res[DATA_WIDTH-1], mul_res[DATA_WIDTH-1:1]};
                  end
                  OP_H_K3: begin
                     xa_in = cur_value_ff + mul_res;
                  end
                  OP_H_SUM: begin
                     div_neg_in = mul_res[DATA_WIDTH-1];
                     div_in     = DIV_W'(prod_mag[DATA_WIDTH-1:1]);
                     rem_in     = '0;
                     div_cnt_in = '0;
                  end
                  default: ;
               endcase
               if (op_ff == OP_H_SUM) begin
                  state_in = S_DIV;
               end else begin
                  op_in    = op_ff + 4'd1;
                  state_in = S_ISSUE;
               end
            end
         end

         // divide the halved magnitude by three
         S_DIV: begin
            div_in     = div_shift;
            rem_in     = rem_v;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_UPD;
            end
         end

         // commit the step
         S_UPD: begin
            cur_value_in = div_neg_ff ? (cur_value_ff - quo) : (cur_value_ff + quo);
            cur_time_in  = end_time_ff;
            steps_in     = steps_ff + limit_type'(1);
            state_in     = S_EMIT;
         end

         // load the response register once it is free
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = field_type'(cur_time_ff);
               rsp_value_in = field_type'(cur_value_ff);
               rsp_done_in  = done_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control, configuration and integration state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         start_time_ff  <= '0;
         start_value_ff <= '0;
         step_size_ff   <= STEP_SIZE_RESET;
         step_limit_ff  <= STEP_LIMIT_RESET;
         coef_const_ff  <= '0;
         coef_time_ff   <= '0;
         coef_value_ff  <= '0;
         cur_time_ff    <= '0;
         cur_value_ff   <= '0;
         steps_ff       <= '0;
         op_ff          <= OP_K1_T;
         div_cnt_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         start_time_ff  <= start_time_in;
         start_value_ff <= start_value_in;
         step_size_ff   <= step_size_in;
         step_limit_ff  <= step_limit_in;
         coef_const_ff  <= coef_const_in;
         coef_time_ff   <= coef_time_in;
         coef_value_ff  <= coef_value_in;
         cur_time_ff    <= cur_time_in;
         cur_value_ff   <= cur_value_in;
         steps_ff       <= steps_in;
         op_ff          <= op_in;
         div_cnt_ff     <= div_cnt_in;
      end
   end

   // working and response payload
   always_ff @(posedge clock) begin
      mid_time_ff  <= mid_time_in;
      end_time_ff  <= end_time_in;
      base_ff      <= base_in;
      k_ff         <= k_in;
      ksum_ff      <= ksum_in;
      xa_ff        <= xa_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      div_neg_ff   <= div_neg_in;
      done_ff      <= done_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_value_ff <= rsp_value_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_time_out  = rsp_time_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_done_res  = rsp_done_ff;

   // checks
   a_mul_start_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy)
      else $error("multiply launched while the multiplier is busy");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == S_MUL))
      else $error("product returned outside the multiply wait");

   a_step_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> (steps_ff < step_limit_ff))
      else $error("step committed beyond the step limit");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT))
      else $error("response raised without an emit");

endmodule
